/* sv/scfp_pkg.sv */
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types, codes and helpers of the serial command frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

	localparam int SCENE_BUF_BYTES_DEF = 512;
	localparam int LEN_FULL_W          = 16;

	localparam logic [7:0] SYNC_ONE   = 8'hC0;
	localparam logic [7:0] SYNC_TWO   = 8'h5D;
	localparam logic [7:0] CMD_BRIGHT = 8'h42;
	localparam logic [7:0] CMD_SCENE  = 8'h4C;
	localparam logic [7:0] PCT_MAX    = 8'd100;

	localparam logic [2:0] PH_SYNC1  = 3'd0;
	localparam logic [2:0] PH_SYNC2  = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_PCT    = 3'd3;
	localparam logic [2:0] PH_LEN_LO = 3'd4;
	localparam logic [2:0] PH_LEN_HI = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;

	localparam logic RES_BRIGHT = 1'b0;
	localparam logic RES_SCENE  = 1'b1;

	// reciprocal of 100 scaled by 2^19, exact for products up to 25500
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] brightness_duty;
		logic [7:0] payload_byte;
		logic [8:0] payload_offset;
		logic [9:0] scene_length;
		logic       scene_done;
	} scfp_result_t;

	// clamped percent to pwm duty, pct * 255 / 100
	function automatic logic [7:0] duty_of(input logic [7:0] b);
		logic [6:0]  pct;
		logic [14:0] scaled;
		logic [27:0] prod;
		pct    = (b > PCT_MAX) ? PCT_MAX[6:0] : b[6:0];
		scaled = {pct, 8'd0} - {8'd0, pct};
		prod   = {13'd0, scaled} * {15'd0, RECIP_100};
		return prod[RECIP_SH +: 8];
	endfunction

endpackage

/* sv/scfp_in_stage.sv */
// ----------------------------------------------------------------------------
// scfp_in_stage
// Input register for received bytes, refilled whenever the parser advances.
// ----------------------------------------------------------------------------
module scfp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* sv/scfp_parser.sv */
// ----------------------------------------------------------------------------
// scfp_parser
// Frame state machine: sync search, command decode, length check and
// payload counting, with the result of the current byte built alongside.
// ----------------------------------------------------------------------------
module scfp_parser #(
	parameter int SCENE_BUF_BYTES = scfp_pkg::SCENE_BUF_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            byte_s1,
	output logic                  res_valid,
	output scfp_pkg::scfp_result_t res
);
	import scfp_pkg::*;

	localparam int LEN_W = $clog2(SCENE_BUF_BYTES + 1);

	logic [2:0]       phase_q, phase_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic [LEN_W-1:0] exp_len_q, exp_len_d;
	logic [LEN_W-1:0] recv_q, recv_d;

	logic [LEN_FULL_W-1:0] len_word;
	logic                  len_ok;
	logic [LEN_W:0]        recv_next;
	logic                  last;
	logic [LEN_FULL_W-1:0] recv_full;
	logic [LEN_FULL_W-1:0] exp_full;
	logic [2:0]            resync;

	assign len_word  = {byte_s1, len_lo_q};
	assign len_ok    = (len_word != '0) &&
		({1'b0, len_word} <= (LEN_FULL_W + 1)'(SCENE_BUF_BYTES));
	assign recv_next = {1'b0, recv_q} + (LEN_W + 1)'(1);
	assign last      = recv_next >= {1'b0, exp_len_q};
	assign recv_full = LEN_FULL_W'(recv_q);
	assign exp_full  = LEN_FULL_W'(exp_len_q);
	assign resync    = (byte_s1 == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;

	always_comb begin
		phase_d   = phase_q;
		len_lo_d  = len_lo_q;
		exp_len_d = exp_len_q;
		recv_d    = recv_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_SYNC2: begin
				phase_d = (byte_s1 == SYNC_TWO) ? PH_CMD : resync;
			end
			PH_CMD: begin
				if (byte_s1 == CMD_BRIGHT) begin
					phase_d = PH_PCT;
				end else if (byte_s1 == CMD_SCENE) begin
					phase_d = PH_LEN_LO;
				end else begin
					phase_d = resync;
				end
			end
			PH_PCT: begin
				res_valid           = 1'b1;
				res.result_kind     = RES_BRIGHT;
				res.brightness_duty = duty_of(byte_s1);
				phase_d             = PH_SYNC1;
			end
			PH_LEN_LO: begin
				len_lo_d = byte_s1;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (len_ok) begin
					exp_len_d = len_word[LEN_W-1:0];
					recv_d    = '0;
					phase_d   = PH_DATA;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_DATA: begin
				res_valid          = 1'b1;
				res.result_kind    = RES_SCENE;
				res.payload_byte   = byte_s1;
				res.payload_offset = recv_full[8:0];
				res.scene_length   = exp_full[9:0];
				res.scene_done     = last;
				recv_d             = recv_next[LEN_W-1:0];
				if (last) begin
					phase_d = PH_SYNC1;
				end
			end
			default: begin
				phase_d = resync;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			len_lo_q  <= '0;
			exp_len_q <= '0;
			recv_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			len_lo_q  <= len_lo_d;
			exp_len_q <= exp_len_d;
			recv_q    <= recv_d;
		end
	end

endmodule

/* sv/scfp_out_stage.sv */
// ----------------------------------------------------------------------------
// scfp_out_stage
// Result register holding one request until the receiver takes it.
// ----------------------------------------------------------------------------
module scfp_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  scfp_pkg::scfp_result_t res,
	output logic                   out_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output scfp_pkg::scfp_result_t res_q
);
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_q <= res;
		end
	end

endmodule

/* sv/serial_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Finds C0 5D framed commands in a serial byte stream and reports
// brightness updates and streamed scene payload bytes.
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per request on rx_byte (in_valid/in_ready)
//   output channel: at most one result per byte (out_valid/out_ready);
//     result_kind picks brightness_duty or the payload fields
//   sync, command and length bytes give no result; a bad length drops the frame
//   throughput: one byte per cycle while the receiver keeps up
//   order: an accepted byte is loaded into the input register, and its result
//     is then loaded into the result register
//   reset: parser returns to the first sync search, both registers empty
//   stall: a full result register holds the parse step; the input register
//     then fills and in_ready drops, so no byte or result is lost
// ----------------------------------------------------------------------------
module serial_command_frame_parser #(
	parameter int SCENE_BUF_BYTES = scfp_pkg::SCENE_BUF_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] brightness_duty,
	output logic [7:0] payload_byte,
	output logic [8:0] payload_offset,
	output logic [9:0] scene_length,
	output logic       scene_done
);
	import scfp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         fire;
	logic         res_valid;
	scfp_result_t res;
	scfp_result_t res_q;

	assign fire = valid_s1 && out_free;

	scfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	scfp_parser #(
		.SCENE_BUF_BYTES (SCENE_BUF_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	scfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign result_kind     = res_q.result_kind;
	assign brightness_duty = res_q.brightness_duty;
	assign payload_byte    = res_q.payload_byte;
	assign payload_offset  = res_q.payload_offset;
	assign scene_length    = res_q.scene_length;
	assign scene_done      = res_q.scene_done;

endmodule
